// ===== hdl/sst_pkg.sv =====
// Package for the sorted symbol table: sizes, operation and status codes,
// and the key normalization function. No dependencies.
`default_nettype none
package sst_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_CHARS   = 8;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam int PW = 24;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam logic CSR_FIELD   = 1'b0;
   localparam logic CSR_USERVAR = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic        detail_flag;
      logic [7:0]  token;
      logic [14:0] index_arg;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  position;
      logic        found;
      logic [7:0]  token_out;
      logic [14:0] ref_out;
      logic        detail_out;
      logic        may_insert;
   } rsp_type;

   typedef struct packed {
      logic       index;
      logic [7:0] data;
   } csr_type;

   // Case fold, cut at the first zero character and past KEY_CHARS.
   function automatic logic [63:0] norm_key(input logic [63:0] k);
      logic [63:0] r;
      logic        live;
      logic [7:0]  c;
      r = '0;
      live = 1'b1;
      for (int i = 0; i < 8; i++) begin
         c = k[56 - 8*i +: 8];
         if (c == 8'd0 || i >= KEY_CHARS) live = 1'b0;
         if (!live) c = 8'd0;
         if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
         r[56 - 8*i +: 8] = c;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/sst_if.sv =====
// Valid/ready channel interfaces for the sorted symbol table.
// Depends on sst_pkg.
`default_nettype none
interface sst_req_if;
   import sst_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface sst_rsp_if;
   import sst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface sst_csr_if;
   import sst_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sorted_symbol_table.sv =====
// Sorted symbol table: binary search over a key memory and a payload memory,
// one read per cycle with registered read data; inserts and removes shift entries.
// A lookup runs the search and a hit check; an insert that misses and finds room
// shifts each entry above the insert point up, then writes; a remove shifts the
// entries above it down; clear and empty lookup answer from idle. One request at a time,
// set by the single read port. Reset clears state and count and sets the token codes only.
`default_nettype none
module sorted_symbol_table (
   input wire logic clock,
   input wire logic reset,
   sst_req_if.sink   req,
   sst_rsp_if.source rsp,
   sst_csr_if.sink   csr
);
   import sst_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PROBE  = 4'd1;
   localparam logic [3:0] S_CMP    = 4'd2;
   localparam logic [3:0] S_HREAD  = 4'd3;
   localparam logic [3:0] S_HCHK   = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_SHRD   = 4'd6;
   localparam logic [3:0] S_SHWR   = 4'd7;
   localparam logic [3:0] S_PUT    = 4'd8;
   localparam logic [3:0] S_RSP    = 4'd9;

   logic [63:0] key_mem [TABLE_DEPTH];
   logic [PW-1:0] pay_mem [TABLE_DEPTH];
   logic [63:0] krd_ff;
   logic [PW-1:0] prd_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [63:0]   wkey;
   logic [PW-1:0] wpay;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   req_type       rq_ff, rq_in;
   rsp_type       out_ff, out_in;
   logic [7:0]    fcode_ff, ucode_ff;
   logic [CW-1:0] mid;

   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[waddr] <= wkey;
         pay_mem[waddr] <= wpay;
      end
      krd_ff <= key_mem[raddr];
      prd_ff <= pay_mem[raddr];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == S_RSP);
   assign rsp.data  = out_ff;
   assign mid = CW'((lo_ff + hi_ff) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fcode_ff <= 8'd0;
         ucode_ff <= 8'd1;
      end else if (csr.valid) begin
         if (csr.data.index == CSR_FIELD) fcode_ff <= csr.data.data;
         else ucode_ff <= csr.data.data;
      end
   end

   always_comb begin
      logic [CW-1:0] pos;
      logic          dd;
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      rq_in = rq_ff;
      out_in = out_ff;
      raddr = mid[AW-1:0];
      we = 1'b0;
      waddr = ptr_ff[AW-1:0];
      wkey = krd_ff;
      wpay = prd_ff;
      pos = lo_ff;
      dd = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               rq_in = req.data;
               rq_in.key = norm_key(req.data.key);
               out_in = '0;
               lo_in = '0;
               hi_in = count_ff;
               case (req.data.op)
                  OP_LOOKUP: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_EMPTY;
                        out_in.may_insert = 1'b1;
                        state_in = S_RSP;
                     end else state_in = S_PROBE;
                  end
                  OP_INSERT: state_in = S_PROBE;
                  OP_REMOVE: begin
                     out_in.position = req.data.index_arg[7:0];
                     if (count_ff == '0) begin
                        out_in.status = ST_EMPTY;
                        state_in = S_RSP;
                     end else if ({1'b0, req.data.index_arg} >= 16'(count_ff)) begin
                        out_in.status = ST_BADPOS;
                        state_in = S_RSP;
                     end else begin
                        ptr_in = CW'(req.data.index_arg);
                        state_in = S_SHRD;
                     end
                  end
                  default: begin
                     count_in = '0;
                     state_in = S_RSP;
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) state_in = S_CMP;
            else state_in = S_HREAD;
         end
         S_CMP: begin
            if (krd_ff < rq_ff.key) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_PROBE;
         end
         S_HREAD: begin
            raddr = lo_ff[AW-1:0];
            state_in = S_HCHK;
         end
         S_HCHK: begin
            out_in.position = pos[7:0];
            if (lo_ff < count_ff && krd_ff == rq_ff.key) begin
               out_in.found = 1'b1;
               out_in.token_out = prd_ff[7:0];
               out_in.ref_out = prd_ff[22:8];
               out_in.detail_out = prd_ff[23];
               if (rq_ff.op == OP_LOOKUP)
                  out_in.may_insert = (prd_ff[7:0] == fcode_ff) &&
                                      (prd_ff[23] == rq_ff.detail_flag);
               state_in = S_RSP;
            end else if (rq_ff.op == OP_LOOKUP) begin
               out_in.status = ST_NOTFOUND;
               out_in.may_insert = 1'b1;
               state_in = S_RSP;
            end else state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (count_ff >= CW'(TABLE_DEPTH)) begin
               out_in = '0;
               out_in.status = ST_FULL;
               state_in = S_RSP;
            end else begin
               ptr_in = count_ff;
               state_in = (count_ff > lo_ff) ? S_SHRD : S_PUT;
            end
         end
         S_SHRD: begin
            // Insert moves entry ptr-1 up; remove moves entry ptr+1 down.
            if (rq_ff.op == OP_INSERT) raddr = AW'(ptr_ff - 1'b1);
            else raddr = AW'(ptr_ff + 1'b1);
            if (rq_ff.op == OP_REMOVE && ptr_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_RSP;
            end else state_in = S_SHWR;
         end
         S_SHWR: begin
            we = 1'b1;
            if (rq_ff.op == OP_INSERT) begin
               ptr_in = ptr_ff - 1'b1;
               state_in = (ptr_ff - 1'b1 > lo_ff) ? S_SHRD : S_PUT;
            end else begin
               ptr_in = ptr_ff + 1'b1;
               state_in = S_SHRD;
            end
         end
         S_PUT: begin
            dd = (rq_ff.token == fcode_ff || rq_ff.token == ucode_ff) ?
                 rq_ff.detail_flag : 1'b0;
            we = 1'b1;
            waddr = lo_ff[AW-1:0];
            wkey = rq_ff.key;
            wpay = {dd, rq_ff.index_arg, rq_ff.token};
            count_in = count_ff + 1'b1;
            out_in.token_out = rq_ff.token;
            out_in.ref_out = rq_ff.index_arg;
            out_in.detail_out = dd;
            state_in = S_RSP;
         end
         S_RSP: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      rq_ff <= rq_in;
      out_ff <= out_in;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while result pending");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search bounds broken");
endmodule
`default_nettype wire
